// ===== rtl/core/bsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfc_pkg
// Shared types and constants of the byte-stuffing frame codec.
// ----------------------------------------------------------------------------
package bsfc_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int FRAME_LEN_W = 16;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] SUB_FLAG  = 8'h5E;
  localparam logic [7:0] SUB_ESC   = 8'h5D;

  typedef struct packed {
    logic [7:0]             data;
    logic                   data_vld;
    logic                   run_last;
    logic                   frame_done;
    logic [FRAME_LEN_W-1:0] length;
    logic                   esc_err;
  } entry_t;

  typedef struct packed {
    logic                           nonempty;
    entry_t [MAX_RESULTS-1:0]       ent;
  } burst_t;

  function automatic entry_t make_entry(input logic [7:0] data,
                                        input logic data_vld,
                                        input logic [FRAME_LEN_W-1:0] length,
                                        input logic esc_err);
    entry_t e;
    e            = '0;
    e.data       = data;
    e.data_vld   = data_vld;
    e.length     = length;
    e.esc_err    = esc_err;
    return e;
  endfunction

endpackage

// ===== rtl/core/byte_stuffing_frame_codec_unit.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_frame_codec_unit
// Byte-stuffing framer and deframer with direction chosen by a register.
// ----------------------------------------------------------------------------
// A transaction is taken every cycle while out_stall is low and each one yields
// at most one result; one yielding more (encode can yield up to four: opening
// flag, escape pair, closing flag) stalls the input until the burst buffer has
// drained, one entry per cycle into the output register while out_stall is low.
// Results pass through the burst buffer, then the output register. Transactions
// that yield nothing (idle or dropped bytes) never occupy the burst buffer, but
// wait while it is full. cfg_wr_data selects encode (0) or decode (1).
// ----------------------------------------------------------------------------
module byte_stuffing_frame_codec_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_last_in_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_out_valid,
  output logic        out_run_last,
  output logic        out_frame_done,
  output logic [15:0] out_frame_length,
  output logic        out_escape_error
);
  import bsfc_pkg::*;

  logic   dir_r;
  logic   take;
  logic   buf_free;
  burst_t burst;
  entry_t out_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
    end
  end

  assign in_stall = !buf_free;
  assign take     = in_valid && buf_free;

  bsfc_expand #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .dir_i     (dir_r),
    .take_i    (take),
    .byte_i    (in_byte_value),
    .present_i (in_byte_present),
    .last_i    (in_last_in_frame),
    .burst_o   (burst)
  );

  bsfc_serialize u_serialize (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (take),
    .burst_i     (burst),
    .free_o      (buf_free),
    .out_vld_o   (out_valid),
    .out_stall_i (out_stall),
    .out_ent_o   (out_ent)
  );

  assign out_byte         = out_ent.data;
  assign out_out_valid    = out_ent.data_vld;
  assign out_run_last     = out_ent.run_last;
  assign out_frame_done   = out_ent.frame_done;
  assign out_frame_length = out_ent.length;
  assign out_escape_error = out_ent.esc_err;

endmodule

// ===== rtl/core/bsfc_expand.sv =====
// ----------------------------------------------------------------------------
// bsfc_expand
// Frame state and per-transaction expansion into up to four result entries.
// ----------------------------------------------------------------------------
module bsfc_expand #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            dir_i,
  input  logic            take_i,
  input  logic [7:0]      byte_i,
  input  logic            present_i,
  input  logic            last_i,
  output bsfc_pkg::burst_t burst_o
);
  import bsfc_pkg::*;

  logic                   frame_open_r, frame_open_nxt;
  logic                   esc_pend_r, esc_pend_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic [COUNT_WIDTH:0]       cnt_sum  [0:MAX_RESULTS];
  logic [COUNT_WIDTH-1:0]     cnt_step [0:MAX_RESULTS];
  logic [COUNT_WIDTH+15:0]    cnt_ext  [0:MAX_RESULTS];
  logic [FRAME_LEN_W-1:0]     len16    [0:MAX_RESULTS];

  entry_t [MAX_RESULTS-1:0] ent;
  logic [2:0]               k;
  logic [2:0]               nres;
  logic                     err;

  always_comb begin
    for (int i = 0; i <= MAX_RESULTS; i++) begin
      cnt_sum[i]  = {1'b0, cnt_r} + (COUNT_WIDTH+1)'(i);
      cnt_step[i] = cnt_sum[i][COUNT_WIDTH] ? '1 : cnt_sum[i][COUNT_WIDTH-1:0];
      cnt_ext[i]  = {16'd0, cnt_step[i]};
      len16[i]    = cnt_ext[i][FRAME_LEN_W-1:0];
    end
  end

  always_comb begin
    ent            = '0;
    k              = 3'd0;
    err            = 1'b0;
    frame_open_nxt = frame_open_r;
    esc_pend_nxt   = esc_pend_r;
    if (!dir_i) begin
      if ((present_i || last_i) && !frame_open_r) begin
        frame_open_nxt = 1'b1;
        ent[k[1:0]]    = make_entry(FLAG_BYTE, 1'b1, len16[k + 3'd1], 1'b0);
        k              = k + 3'd1;
      end
      if (present_i) begin
        frame_open_nxt = 1'b1;
        if (byte_i == FLAG_BYTE || byte_i == ESC_BYTE) begin
          ent[k[1:0]] = make_entry(ESC_BYTE, 1'b1, len16[k + 3'd1], 1'b0);
          k           = k + 3'd1;
          ent[k[1:0]] = make_entry((byte_i == FLAG_BYTE) ? SUB_FLAG : SUB_ESC, 1'b1,
                                   len16[k + 3'd1], 1'b0);
          k           = k + 3'd1;
        end else begin
          ent[k[1:0]] = make_entry(byte_i, 1'b1, len16[k + 3'd1], 1'b0);
          k           = k + 3'd1;
        end
      end
      if (last_i) begin
        ent[k[1:0]] = make_entry(FLAG_BYTE, 1'b1, len16[k + 3'd1], 1'b0);
        k           = k + 3'd1;
      end
    end else begin
      if (present_i) begin
        frame_open_nxt = 1'b1;
        if (byte_i == FLAG_BYTE) begin
          esc_pend_nxt = esc_pend_r;
        end else if (byte_i == ESC_BYTE) begin
          esc_pend_nxt = 1'b1;
        end else if (esc_pend_r) begin
          esc_pend_nxt = 1'b0;
          if (byte_i == SUB_FLAG) begin
            ent[0] = make_entry(FLAG_BYTE, 1'b1, len16[1], 1'b0);
            k      = 3'd1;
          end else if (byte_i == SUB_ESC) begin
            ent[0] = make_entry(ESC_BYTE, 1'b1, len16[1], 1'b0);
            k      = 3'd1;
          end else begin
            err = 1'b1;
          end
        end else begin
          ent[0] = make_entry(byte_i, 1'b1, len16[1], 1'b0);
          k      = 3'd1;
        end
      end
    end

    // bare result: decode drop that reports an error or closes the frame
    nres = k;
    if (k == 3'd0 && (err || last_i)) begin
      ent[0] = make_entry(8'h00, 1'b0, len16[0], err);
      nres   = 3'd1;
    end
    if (nres != 3'd0) begin
      ent[nres[1:0] - 2'd1].run_last   = 1'b1;
      ent[nres[1:0] - 2'd1].frame_done = last_i;
    end

    cnt_nxt = cnt_step[k];
    if (last_i) begin
      frame_open_nxt = 1'b0;
      esc_pend_nxt   = 1'b0;
      cnt_nxt        = '0;
    end
  end

  assign burst_o.nonempty = (nres != 3'd0);
  assign burst_o.ent      = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      esc_pend_r   <= 1'b0;
      cnt_r        <= '0;
    end else if (take_i) begin
      frame_open_r <= frame_open_nxt;
      esc_pend_r   <= esc_pend_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_open: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> frame_open_r)
    else $error("byte count nonzero outside an open frame");

  a_err_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_o.nonempty && burst_o.ent[0].esc_err) |-> (dir_i && !burst_o.ent[0].data_vld))
    else $error("escape error outside decode or with a data byte");
`endif

endmodule

// ===== rtl/core/bsfc_serialize.sv =====
// ----------------------------------------------------------------------------
// bsfc_serialize
// Burst buffer and output register; drains one result entry per cycle unless out_stall holds the output register.
// ----------------------------------------------------------------------------
module bsfc_serialize (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  bsfc_pkg::burst_t  burst_i,
  output logic              free_o,
  output logic              out_vld_o,
  input  logic              out_stall_i,
  output bsfc_pkg::entry_t  out_ent_o
);
  import bsfc_pkg::*;

  entry_t [MAX_RESULTS-1:0] buf_ent_r;
  logic [1:0]               buf_idx_r;
  logic                     buf_vld_r;
  entry_t                   out_ent_r;
  logic                     out_vld_r;

  logic   out_load;
  logic   buf_last;
  logic   load_new;
  entry_t head;

  assign head     = buf_ent_r[buf_idx_r];
  assign buf_last = head.run_last;
  assign out_load = buf_vld_r && (!out_vld_r || !out_stall_i);
  assign free_o   = !buf_vld_r || (out_load && buf_last);
  assign load_new = load_i && burst_i.nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      buf_idx_r <= 2'd0;
    end else if (load_new) begin
      buf_vld_r <= 1'b1;
      buf_idx_r <= 2'd0;
    end else if (out_load) begin
      if (buf_last) begin
        buf_vld_r <= 1'b0;
      end else begin
        buf_idx_r <= buf_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      buf_ent_r <= burst_i.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ent_r <= head;
    end
  end

  assign out_vld_o = out_vld_r;
  assign out_ent_o = out_ent_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_new |-> (!buf_vld_r || (out_load && buf_last)))
    else $error("burst buffer overwritten before drained");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ent_r.frame_done) |-> out_ent_r.run_last)
    else $error("frame done on a result that is not the last of its transaction");

  a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ent_r.data_vld) |-> (out_ent_r.data == 8'h00 && out_ent_r.run_last))
    else $error("bare result carries a byte or is not final");
`endif

endmodule

// ===== verif/tb_byte_stuffing_frame_codec_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stuffing_frame_codec_unit
// Self-checking bench for the byte-stuffing framer and deframer. A queue-fed
// driver offers byte transactions. A monitor compares every output transaction,
// field by field, with a bench-side model of the flag and escape rules. The
// run covers directed corner frames in both directions and random frames under
// several idling mixes. It also has a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_byte_stuffing_frame_codec_unit;
  import bsfc_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       present;
    logic       last;
  } byte_item_t;

  localparam int SEND_IDLE[4]  = '{0, 63, 0, 17};
  localparam int RECV_STALL[4] = '{0, 0, 63, 17};
  localparam int HOLDOFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_last_in_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_out_valid;
  logic        out_run_last;
  logic        out_frame_done;
  logic [15:0] out_frame_length;
  logic        out_escape_error;

  byte_item_t  byte_items_q[$];
  entry_t      codec_out_q[$];

  logic        mdl_dir = 1'b0;
  logic        mdl_open = 1'b0;
  logic        mdl_esc = 1'b0;
  logic [15:0] mdl_count = 16'd0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        holdoff = 1'b0;
  int          mismatches = 0;

  byte_stuffing_frame_codec_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_byte_present  (in_byte_present),
    .in_last_in_frame (in_last_in_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_out_valid    (out_out_valid),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done),
    .out_frame_length (out_frame_length),
    .out_escape_error (out_escape_error)
  );

  always #5 clk = ~clk;

  function automatic entry_t count_byte(input logic [7:0] value);
    entry_t e;
    if (mdl_count != 16'hFFFF) begin
      mdl_count = mdl_count + 16'd1;
    end
    e          = '0;
    e.data     = value;
    e.data_vld = 1'b1;
    e.length   = mdl_count;
    return e;
  endfunction

  function automatic void compute_codec_output(input byte_item_t item);
    entry_t res [MAX_RESULTS];
    int     n;
    logic   bad_esc;
    n       = 0;
    bad_esc = 1'b0;
    if (!mdl_dir) begin
      if ((item.present || item.last) && !mdl_open) begin
        mdl_open = 1'b1;
        res[n]   = count_byte(FLAG_BYTE);
        n++;
      end
      if (item.present) begin
        if (item.value == FLAG_BYTE || item.value == ESC_BYTE) begin
          res[n] = count_byte(ESC_BYTE);
          n++;
          res[n] = count_byte(item.value == FLAG_BYTE ? SUB_FLAG : SUB_ESC);
          n++;
        end else begin
          res[n] = count_byte(item.value);
          n++;
        end
      end
      if (item.last) begin
        res[n] = count_byte(FLAG_BYTE);
        n++;
      end
    end else begin
      if (item.present) begin
        mdl_open = 1'b1;
        if (item.value == ESC_BYTE) begin
          mdl_esc = 1'b1;
        end else if (item.value != FLAG_BYTE) begin
          if (!mdl_esc) begin
            res[n] = count_byte(item.value);
            n++;
          end else begin
            mdl_esc = 1'b0;
            if (item.value == SUB_FLAG) begin
              res[n] = count_byte(FLAG_BYTE);
              n++;
            end else if (item.value == SUB_ESC) begin
              res[n] = count_byte(ESC_BYTE);
              n++;
            end else begin
              bad_esc = 1'b1;
            end
          end
        end
      end
      if (n == 0 && (bad_esc || item.last)) begin
        res[0]         = '0;
        res[0].esc_err = bad_esc;
        res[0].length  = mdl_count;
        n              = 1;
      end
    end
    if (n > 0) begin
      res[n-1].run_last   = 1'b1;
      res[n-1].frame_done = item.last;
    end
    for (int i = 0; i < n; i++) begin
      codec_out_q.push_back(res[i]);
    end
    if (item.last) begin
      mdl_open  = 1'b0;
      mdl_esc   = 1'b0;
      mdl_count = 16'd0;
    end
  endfunction

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40) begin
        $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    byte_item_t taken;
    byte_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.value   = in_byte_value;
        taken.present = in_byte_present;
        taken.last    = in_last_in_frame;
        compute_codec_output(taken);
      end
      if (!in_valid || !in_stall) begin
        if (byte_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item        = byte_items_q.pop_front();
          in_byte_value    <= next_item.value;
          in_byte_present  <= next_item.present;
          in_last_in_frame <= next_item.last;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    entry_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (codec_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 40) begin
            $display("%0t: out transaction expected none got byte %02h", $time, out_byte);
          end
        end else begin
          want = codec_out_q.pop_front();
          check_field("out_byte", 16'(want.data), 16'(out_byte));
          check_field("out_out_valid", 16'(want.data_vld), 16'(out_out_valid));
          check_field("out_run_last", 16'(want.run_last), 16'(out_run_last));
          check_field("out_frame_done", 16'(want.frame_done), 16'(out_frame_done));
          check_field("out_frame_length", want.length, out_frame_length);
          check_field("out_escape_error", 16'(want.esc_err), 16'(out_escape_error));
        end
      end
      out_stall <= holdoff || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void push_item(input logic [7:0] value, input logic present,
                                    input logic last);
    byte_item_t it;
    it.value   = value;
    it.present = present;
    it.last    = last;
    byte_items_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0, 1: return FLAG_BYTE;
      2, 3: return ESC_BYTE;
      4: return SUB_FLAG;
      5: return SUB_ESC;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void maybe_idle();
    if ($urandom_range(9) == 0) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endfunction

  function automatic int queue_raw_frame();
    int len;
    bit sep_close;
    len       = $urandom_range(10);
    sep_close = (len == 0) || ($urandom_range(2) == 0);
    for (int i = 0; i < len; i++) begin
      maybe_idle();
      push_item(pick_byte(), 1'b1, !sep_close && i == len - 1);
    end
    if (sep_close) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
    return len + (sep_close ? 1 : 0);
  endfunction

  function automatic int queue_stuffed_frame();
    int         len;
    int         cnt;
    logic [7:0] raw;
    len = $urandom_range(10);
    cnt = 0;
    if ($urandom_range(3) != 0) begin
      push_item(FLAG_BYTE, 1'b1, 1'b0);
      cnt++;
    end
    for (int i = 0; i < len; i++) begin
      raw = pick_byte();
      maybe_idle();
      if (raw == FLAG_BYTE || raw == ESC_BYTE) begin
        push_item(ESC_BYTE, 1'b1, 1'b0);
        push_item(raw == FLAG_BYTE ? SUB_FLAG : SUB_ESC, 1'b1, 1'b0);
        cnt += 2;
      end else begin
        push_item(raw, 1'b1, 1'b0);
        cnt++;
      end
    end
    if ($urandom_range(1) == 0) begin
      push_item(FLAG_BYTE, 1'b1, 1'b1);
    end else begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
    return cnt + 1;
  endfunction

  function automatic int queue_noise_frame();
    int len;
    len = 1 + $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      maybe_idle();
      push_item(pick_byte(), 1'b1, i == len - 1);
    end
    return len;
  endfunction

  function automatic void queue_frames(input logic dir, input int target);
    int cnt;
    cnt = 0;
    while (cnt < target) begin
      if (!dir) begin
        cnt += queue_raw_frame();
      end else if ($urandom_range(3) != 0) begin
        cnt += queue_stuffed_frame();
      end else begin
        cnt += queue_noise_frame();
      end
    end
  endfunction

  task automatic wait_quiet();
    while (byte_items_q.size() != 0 || in_valid || codec_out_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic dir, input int send_pct, input int recv_pct);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= dir;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_dir   = dir;
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(1'b0, 0, 0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h3C, 1'b0, 1'b0);
    push_item(FLAG_BYTE, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(FLAG_BYTE, 1'b1, 1'b0);
    push_item(8'hC3, 1'b0, 1'b1);
    push_item(ESC_BYTE, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);

    set_mode(1'b1, 0, 0);
    push_item(FLAG_BYTE, 1'b1, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(SUB_FLAG, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(8'h33, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(FLAG_BYTE, 1'b1, 1'b0);
    push_item(SUB_FLAG, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(SUB_ESC, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(8'h96, 1'b0, 1'b1);
    push_item(ESC_BYTE, 1'b1, 1'b0);
    push_item(8'h12, 1'b1, 1'b1);
    push_item(8'hA5, 1'b0, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph % 2 == 1, SEND_IDLE[ph / 2], RECV_STALL[ph / 2]);
      queue_frames(ph % 2 == 1, 28);
    end

    // hold the receiver off while the sender keeps offering
    set_mode(1'b0, 0, 0);
    holdoff <= 1'b1;
    queue_frames(1'b0, 24);
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holdoff <= 1'b0;

    wait_quiet();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && codec_out_q.size() == 0) begin
      $display("tb_byte_stuffing_frame_codec_unit: clean");
    end else begin
      $display("tb_byte_stuffing_frame_codec_unit: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_byte_stuffing_frame_codec_unit: errors");
    $finish;
  end

endmodule
